// File: hdl/cfp_pkg.sv
// Shared types and constants of the command frame parser.
package cfp_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;
  localparam logic [3:0]  NO_FIELD = 4'd15;

  typedef enum logic [1:0] {
    TK_FIELD   = 2'd0,
    TK_PAYLOAD = 2'd1,
    TK_VERDICT = 2'd2
  } token_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BAD_CHECK = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [3:0]  field_id;
    logic [15:0] value;
    logic [1:0]  status;
    logic        run_end;
  } result_t;

  // Header field number carried by each header byte position.
  function automatic logic [3:0] field_at(input logic [3:0] pos);
    logic [3:0] fid;
    case (pos)
      4'd2:    fid = 4'd11;
      4'd3:    fid = 4'd0;
      4'd4:    fid = 4'd1;
      4'd5:    fid = 4'd2;
      4'd6:    fid = 4'd3;
      4'd7:    fid = 4'd4;
      4'd8:    fid = 4'd5;
      4'd9:    fid = 4'd6;
      4'd11:   fid = 4'd7;
      4'd12:   fid = 4'd8;
      4'd13:   fid = 4'd9;
      4'd15:   fid = 4'd10;
      default: fid = NO_FIELD;
    endcase
    return fid;
  endfunction

endpackage

// File: hdl/command_frame_parser.sv
// Top level of the command frame parser: byte tracking, verdict and result queue.
//
// Usage: bytes of a received buffer enter on the in_ channel, one item per byte,
// with in_buffer_end set on the last byte of the buffer. Each byte updates the
// position counter, length, hold byte and running XOR in the cycle it is taken.
// Header bytes 2-9, 11-13 and 15 yield header field items (16-bit fields on
// their high byte), payload bytes yield payload items, and the last byte adds a
// verdict item. The checksum byte and trailing bytes yield nothing unless they
// end the buffer. Results enter a four-entry queue and leave on the out_ channel;
// a byte's results are written into the queue registers when the byte is taken.
// Throughput: one byte per cycle while the queue has room for two results. The
// queue depth sets this: in_stall rises when three or more results are queued.
// A byte with two results drains as two items, so back-pressure follows.
// When the receiver raises out_stall, the head item holds and the queue fills;
// after that in_stall holds off new bytes until items drain.
// The start byte register is written on the cfg_ channel (always ready) and is
// compared when byte 0 arrives.
// Reset (rst_n low, synchronous) empties the queue, rearms for byte 0 and sets
// the start byte to 2. After each verdict all frame state returns to zero.
module command_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_kind,
  output logic [3:0]  out_field_id,
  output logic [15:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_start_byte
);
  import cfp_pkg::*;

  localparam logic [16:0] MaxPay = 17'(MAX_PAYLOAD);

  // Frame state
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic        seen_r, seen_nxt;
  logic [16:0] pay_end_r, pay_end_nxt;  // position of the checksum byte
  logic [7:0]  start_byte_r;

  // Result queue
  result_t     q_mem [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r;

  logic        in_acc, out_acc;
  logic        is_hdr;
  logic [3:0]  fid;
  logic [15:0] word;
  logic [16:0] plen;
  logic        r0_vld;
  result_t     r0, verdict, slot0, slot1;
  logic [1:0]  npush;
  logic [17:0] count, len_p4;
  logic [1:0]  st;

  assign cfg_ready = 1'b1;
  assign in_stall  = (cnt_r >= 3'd3);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    is_hdr = (pos_r[16:4] == 13'd0);
    fid    = field_at(pos_r[3:0]);
    word   = {in_data_byte, hold_r};
    plen   = 17'd0;

    pos_nxt      = (pos_r < POS_MAX) ? pos_r + 17'd1 : pos_r;
    len_nxt      = len_r;
    hold_nxt     = hold_r;
    xor_nxt      = xor_r;
    start_ok_nxt = start_ok_r;
    chk_nxt      = chk_r;
    seen_nxt     = seen_r;
    pay_end_nxt  = pay_end_r;

    r0_vld = 1'b0;
    r0     = '0;

    if (is_hdr) begin
      if (pos_r[3:0] == 4'd0) start_ok_nxt = (in_data_byte == start_byte_r);
      if (pos_r[3:0] == 4'd1 || pos_r[3:0] == 4'd10 || pos_r[3:0] == 4'd14) begin
        hold_nxt = in_data_byte;
      end
      if (pos_r[3:0] == 4'd2) begin
        len_nxt = word;
        if (word > 16'd13) plen = {1'b0, word - 16'd13};
        if (plen > MaxPay) plen = MaxPay;
        pay_end_nxt = plen + 17'(HEADER_BYTES);
      end
      if (pos_r[3:0] >= 4'd3) xor_nxt = xor_r ^ in_data_byte;
      if (fid != NO_FIELD) begin
        r0_vld        = 1'b1;
        r0.token_kind = TK_FIELD;
        r0.field_id   = fid;
        if (pos_r[3:0] == 4'd2 || pos_r[3:0] == 4'd11 || pos_r[3:0] == 4'd15) begin
          r0.value = word;
        end else begin
          r0.value = {8'd0, in_data_byte};
        end
      end
    end else if (pos_r < pay_end_r) begin
      // payload byte: fold into the checksum and report it
      xor_nxt       = xor_r ^ in_data_byte;
      r0_vld        = 1'b1;
      r0.token_kind = TK_PAYLOAD;
      r0.value      = {8'd0, in_data_byte};
    end else if (pos_r == pay_end_r) begin
      chk_nxt  = in_data_byte;
      seen_nxt = 1'b1;
    end
    r0.run_end = !in_buffer_end;

    // Verdict on the state as it stands after this byte
    count  = {1'b0, pos_r} + 18'd1;
    len_p4 = {2'b0, len_nxt} + 18'd4;
    if (count < 18'(HEADER_BYTES) || count < len_p4 || !seen_nxt) begin
      st = ST_SHORT;
    end else if (!start_ok_nxt) begin
      st = ST_BAD_START;
    end else if (chk_nxt != xor_nxt) begin
      st = ST_BAD_CHECK;
    end else begin
      st = ST_OK;
    end
    verdict            = '0;
    verdict.token_kind = TK_VERDICT;
    verdict.status     = st;
    verdict.run_end    = 1'b1;

    if (r0_vld) begin
      slot0 = r0;
      slot1 = verdict;
      npush = in_buffer_end ? 2'd2 : 2'd1;
    end else begin
      slot0 = verdict;
      slot1 = verdict;
      npush = in_buffer_end ? 2'd1 : 2'd0;
    end

    // Rearm for a new buffer after the last byte
    if (in_buffer_end) begin
      pos_nxt      = '0;
      len_nxt      = '0;
      hold_nxt     = '0;
      xor_nxt      = '0;
      start_ok_nxt = 1'b0;
      chk_nxt      = '0;
      seen_nxt     = 1'b0;
      pay_end_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      len_r      <= '0;
      hold_r     <= '0;
      xor_r      <= '0;
      start_ok_r <= 1'b0;
      chk_r      <= '0;
      seen_r     <= 1'b0;
      pay_end_r  <= '0;
    end else if (in_acc) begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      hold_r     <= hold_nxt;
      xor_r      <= xor_nxt;
      start_ok_r <= start_ok_nxt;
      chk_r      <= chk_nxt;
      seen_r     <= seen_nxt;
      pay_end_r  <= pay_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      start_byte_r <= cfg_start_byte;
    end
  end

  // Queue payload: write up to two entries per accepted byte
  always_ff @(posedge clk) begin
    if (in_acc && npush != 2'd0) begin
      q_mem[wr_ptr_r] <= slot0;
      if (npush == 2'd2) q_mem[wr_ptr_r + 2'd1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + npush;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + (in_acc ? {1'b0, npush} : 3'd0) - {2'b0, out_acc};
    end
  end

  assign out_token_kind = q_mem[rd_ptr_r].token_kind;
  assign out_field_id   = q_mem[rd_ptr_r].field_id;
  assign out_value      = q_mem[rd_ptr_r].value;
  assign out_status     = q_mem[rd_ptr_r].status;
  assign out_run_end    = q_mem[rd_ptr_r].run_end;

endmodule

// File: hdl/cfp_checker.sv
// Port-level checks of the command frame parser, bound to its top level.
module cfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_token_kind,
  input logic [3:0]  out_field_id,
  input logic [15:0] out_value,
  input logic [1:0]  out_status,
  input logic        out_run_end
);
  import cfp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
    $stable(out_token_kind) && $stable(out_status) && $stable(out_run_end))
    else $error("stalled result changed");

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // A verdict always closes the results of its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == TK_VERDICT |-> out_run_end &&
    out_value == 16'd0 && out_field_id == 4'd0)
    else $error("malformed verdict");

  // Field and payload items carry no status.
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != TK_VERDICT |-> out_status == ST_OK)
    else $error("status on a data item");

  // Payload items carry a byte and no field number.
  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == TK_PAYLOAD |->
    out_value[15:8] == 8'd0 && out_field_id == 4'd0)
    else $error("malformed payload item");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (.*);
